// ----- sv/wla_pkg.sv -----
// shared types and constants for the weighted lamport admission block
// no dependencies
`default_nettype none
package wla_pkg;

   typedef enum logic [2:0] {
      MODE_LOCAL_REQ = 3'd0,
      MODE_RX_REQ    = 3'd1,
      MODE_RX_RSP    = 3'd2,
      MODE_RX_REL    = 3'd3,
      MODE_EVAL      = 3'd4,
      MODE_LOCAL_REL = 3'd5,
      MODE_TICK      = 3'd6,
      MODE_NONE      = 3'd7
   } mode_type;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;
   localparam logic [1:0] KIND_RELEASE = 2'd3;

   localparam logic [1:0] ST_QUEUED   = 2'd0;
   localparam logic [1:0] ST_RIDING   = 2'd1;
   localparam logic [1:0] ST_FINISHED = 2'd2;

   localparam logic [1:0] REG_OWN_RANK   = 2'd0;
   localparam logic [1:0] REG_NODE_COUNT = 2'd1;
   localparam logic [1:0] REG_OWN_WEIGHT = 2'd2;
   localparam logic [1:0] REG_CAPACITY   = 2'd3;

   localparam logic [13:0] CAPACITY_RESET = 14'd200;
   localparam logic [13:0] WEIGHT_SAT     = 14'd16383;

   // one queued message between front and back
   typedef struct packed {
      mode_type    mode;
      logic [3:0]  peer_rank;
      logic [31:0] peer_clock;
      logic [31:0] peer_stamp;
      logic [9:0]  peer_weight;
      logic [1:0]  peer_state;
      logic        rank_ok;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [3:0]  send_target;
      logic [31:0] send_clock;
      logic [31:0] send_stamp;
      logic [1:0]  send_state;
      logic        all_granted;
      logic        may_enter;
      logic [13:0] weight_ahead;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/wla_front.sv -----
// front end: takes requests, classifies rank, feeds a two-entry queue
// depends on wla_pkg
`default_nettype none
module wla_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_mode,
   input  wire logic [3:0]       req_peer_rank,
   input  wire logic [31:0]      req_peer_clock,
   input  wire logic [31:0]      req_peer_stamp,
   input  wire logic [9:0]       req_peer_weight,
   input  wire logic [1:0]       req_peer_state,
   input  wire logic [3:0]       own_rank,
   input  wire logic [4:0]       live_count,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output wla_pkg::cmd_type      cmd
);

   wla_pkg::cmd_type q_ff [2];
   logic             rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff, count_in;
   wla_pkg::cmd_type incoming;
   logic             push, pop;

   // classify the incoming message
   always_comb begin
      incoming.mode        = wla_pkg::mode_type'(req_mode);
      incoming.peer_rank   = req_peer_rank;
      incoming.peer_clock  = req_peer_clock;
      incoming.peer_stamp  = req_peer_stamp;
      incoming.peer_weight = req_peer_weight;
      incoming.peer_state  = req_peer_state;
      incoming.rank_ok     = ({1'b0, req_peer_rank} < live_count) &&
                             (req_peer_rank != own_rank);
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule
`default_nettype wire

// ----- sv/wla_back.sv -----
// back end: node state, peer table, evaluate walk and result register
// depends on wla_pkg
`default_nettype none
module wla_back #(
   parameter int NODES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire wla_pkg::cmd_type cmd,
   input  wire logic [3:0]       own_rank,
   input  wire logic [4:0]       live_count,
   input  wire logic [9:0]       own_weight,
   input  wire logic [13:0]      capacity,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output wla_pkg::rsp_type      rsp
);

   localparam int TN = (NODES < 16) ? NODES : 16;
   localparam int IW = (TN > 1) ? $clog2(TN) : 1;
   localparam int CW = $clog2(TN + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] clock_ff, clock_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [1:0]  nstate_ff, nstate_in;
   logic [3:0]  grant_ff, grant_in;
   logic [TN-1:0] valid_ff, valid_in;
   logic [31:0] tstamp_ff [TN];
   logic [9:0]  tweight_ff [TN];
   logic [CW-1:0] idx_ff, idx_in;
   logic [13:0] ahead_ff, ahead_in;
   logic        rsp_valid_ff, rsp_valid_in;
   wla_pkg::rsp_type rsp_ff, rsp_in;

   logic        take;
   logic        out_free;
   logic [31:0] synced;
   logic        tbl_wr, tbl_new;
   logic [IW-1:0] rank_idx, walk_idx;
   logic [4:0]  idx_wide;
   logic        walk_hit, walk_ok;
   logic [14:0] sum;
   logic [3:0]  grant_inc;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign synced    = ((clock_ff < cmd.peer_clock) ? cmd.peer_clock : clock_ff) + 32'd1;
   assign rank_idx  = cmd.peer_rank[IW-1:0];
   assign walk_idx  = idx_ff[IW-1:0];
   assign idx_wide  = 5'(idx_ff);
   assign grant_inc = grant_ff + 4'd1;
   assign tbl_new   = ({1'b0, cmd.peer_rank} < 5'(TN)) ? !valid_ff[rank_idx] : 1'b0;

   // evaluate walk: one table entry per cycle
   always_comb begin
      walk_ok  = (idx_wide < live_count) &&
                 (idx_wide != {1'b0, own_rank}) && valid_ff[walk_idx];
      walk_hit = walk_ok && ((tstamp_ff[walk_idx] < stamp_ff) ||
                 ((tstamp_ff[walk_idx] == stamp_ff) &&
                  (idx_wide < {1'b0, own_rank})));
      sum      = {1'b0, ahead_ff} + {5'd0, tweight_ff[walk_idx]};
   end

   // command execution
   always_comb begin
      state_in     = state_ff;
      clock_in     = clock_ff;
      stamp_in     = stamp_ff;
      nstate_in    = nstate_ff;
      grant_in     = grant_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      ahead_in     = ahead_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tbl_wr       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               case (cmd.mode)
                  wla_pkg::MODE_LOCAL_REQ: begin
                     nstate_in         = wla_pkg::ST_QUEUED;
                     rsp_in.send_kind  = wla_pkg::KIND_REQUEST;
                     rsp_in.send_clock = clock_ff;
                     rsp_in.send_stamp = stamp_ff;
                     rsp_in.send_state = wla_pkg::ST_QUEUED;
                  end
                  wla_pkg::MODE_RX_REQ: begin
                     tbl_wr             = cmd.rank_ok;
                     clock_in           = synced;
                     rsp_in.send_kind   = wla_pkg::KIND_REPLY;
                     rsp_in.send_target = cmd.peer_rank;
                     rsp_in.send_clock  = synced;
                     rsp_in.send_stamp  = stamp_ff;
                     rsp_in.send_state  = nstate_ff;
                  end
                  wla_pkg::MODE_RX_RSP: begin
                     if (cmd.peer_clock >= stamp_ff) begin
                        tbl_wr   = cmd.rank_ok && (cmd.peer_state == wla_pkg::ST_QUEUED ||
                                   cmd.peer_state == wla_pkg::ST_RIDING);
                        clock_in = synced;
                        grant_in = grant_inc;
                        if ({1'b0, grant_inc} == live_count - 5'd1) begin
                           rsp_in.all_granted = 1'b1;
                           grant_in           = 4'd0;
                        end
                     end
                  end
                  wla_pkg::MODE_RX_REL: begin
                     if (cmd.rank_ok) begin
                        valid_in[rank_idx] = 1'b0;
                     end
                     clock_in = synced;
                  end
                  wla_pkg::MODE_EVAL: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                     ahead_in     = {4'd0, own_weight};
                     idx_in       = '0;
                     state_in     = S_WALK;
                  end
                  wla_pkg::MODE_LOCAL_REL: begin
                     clock_in          = clock_ff + 32'd1;
                     stamp_in          = clock_ff + 32'd1;
                     nstate_in         = wla_pkg::ST_FINISHED;
                     rsp_in.send_kind  = wla_pkg::KIND_RELEASE;
                     rsp_in.send_clock = clock_ff + 32'd1;
                     rsp_in.send_stamp = clock_ff + 32'd1;
                     rsp_in.send_state = wla_pkg::ST_FINISHED;
                  end
                  wla_pkg::MODE_TICK: begin
                     clock_in = clock_ff + 32'd1;
                     stamp_in = clock_ff + 32'd1;
                  end
                  default: begin
                  end
               endcase
               if (tbl_wr && tbl_new) begin
                  valid_in[rank_idx] = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (walk_hit) begin
               ahead_in = sum[14] ? wla_pkg::WEIGHT_SAT : sum[13:0];
            end
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(TN - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in              = '0;
               rsp_in.weight_ahead = ahead_ff;
               rsp_in.may_enter    = (ahead_ff <= capacity);
               rsp_valid_in        = 1'b1;
               if (ahead_ff <= capacity) begin
                  nstate_in = wla_pkg::ST_RIDING;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clock_ff     <= '0;
         stamp_ff     <= '0;
         nstate_ff    <= wla_pkg::ST_QUEUED;
         grant_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         stamp_ff     <= stamp_in;
         nstate_ff    <= nstate_in;
         grant_ff     <= grant_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      ahead_ff <= ahead_in;
      rsp_ff   <= rsp_in;
   end

   // peer table: weight only while the entry is not valid, stamp on every write
   always_ff @(posedge clock) begin
      if (take && tbl_wr) begin
         tstamp_ff[rank_idx] <= cmd.peer_stamp;
         if (tbl_new) begin
            tweight_ff[rank_idx] <= cmd.peer_weight;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/weighted_lamport_admission.sv -----
// top level of the weighted lamport admission node: registers, front, back
// depends on wla_pkg, wla_front, wla_back
//
//   channel  ports   direction  role
//   req_     valid/ready  in    one message or local action per transfer
//   rsp_     valid/ready  out   one result per request transfer
//   csr_     valid/ready  in    register index and write data
//
// each item other than evaluate passes through a queue entry and then the back
// end's result register; evaluate walks the peer table one entry per cycle,
// min(NODES,16) entries, before its result is registered.
// reset clears clock, own stamp, state, grant count and table valid bits.
// a held result stalls the back end; the front keeps taking transfers until
// both queue entries are full and then drops req_ready.
`default_nettype none
module weighted_lamport_admission #(
   parameter int NODES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [3:0]  req_peer_rank,
   input  wire logic [31:0] req_peer_clock,
   input  wire logic [31:0] req_peer_stamp,
   input  wire logic [9:0]  req_peer_weight,
   input  wire logic [1:0]  req_peer_state,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_send_kind,
   output logic [3:0]       rsp_send_target,
   output logic [31:0]      rsp_send_clock,
   output logic [31:0]      rsp_send_stamp,
   output logic [1:0]       rsp_send_state,
   output logic             rsp_all_granted,
   output logic             rsp_may_enter,
   output logic [13:0]      rsp_weight_ahead,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int TN = (NODES < 16) ? NODES : 16;

   logic [3:0]  own_rank_ff;
   logic [4:0]  node_count_ff;
   logic [9:0]  own_weight_ff;
   logic [13:0] capacity_ff;
   logic [4:0]  live_count;
   logic        cmd_valid, cmd_ready;
   wla_pkg::cmd_type cmd;
   wla_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_rank_ff   <= 4'd0;
         node_count_ff <= 5'd4;
         own_weight_ff <= 10'd50;
         capacity_ff   <= wla_pkg::CAPACITY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            wla_pkg::REG_OWN_RANK:   own_rank_ff   <= csr_data[3:0];
            wla_pkg::REG_NODE_COUNT: node_count_ff <= csr_data[4:0];
            wla_pkg::REG_OWN_WEIGHT: own_weight_ff <= csr_data[9:0];
            wla_pkg::REG_CAPACITY:   capacity_ff   <= csr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   // node count clamped to between 2 and the table size
   always_comb begin
      live_count = node_count_ff;
      if (node_count_ff < 5'd2) live_count = 5'd2;
      if (node_count_ff > 5'(TN)) live_count = 5'(TN);
   end

   wla_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_peer_rank,
      .req_peer_clock, .req_peer_stamp, .req_peer_weight, .req_peer_state,
      .own_rank(own_rank_ff), .live_count, .cmd_valid, .cmd_ready, .cmd
   );

   wla_back #(.NODES(NODES)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .own_rank(own_rank_ff), .live_count, .own_weight(own_weight_ff),
      .capacity(capacity_ff), .rsp_valid, .rsp_ready, .rsp
   );

   assign rsp_send_kind    = rsp.send_kind;
   assign rsp_send_target  = rsp.send_target;
   assign rsp_send_clock   = rsp.send_clock;
   assign rsp_send_stamp   = rsp.send_stamp;
   assign rsp_send_state   = rsp.send_state;
   assign rsp_all_granted  = rsp.all_granted;
   assign rsp_may_enter    = rsp.may_enter;
   assign rsp_weight_ahead = rsp.weight_ahead;

endmodule
`default_nettype wire
